FILE: src/jrs_pkg.sv
// Shared types and constants for the joystick rate shaper.
// Used by jrs_div_pipe and joystick_rate_shaper; no dependencies.
package jrs_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_IN_DB      = 3'd1;
  localparam logic [2:0] REG_CUT_LOW    = 3'd2;
  localparam logic [2:0] REG_CUT_HIGH   = 3'd3;
  localparam logic [2:0] REG_GAIN_LOW   = 3'd4;
  localparam logic [2:0] REG_GAIN_MID   = 3'd5;
  localparam logic [2:0] REG_LIMIT      = 3'd6;
  localparam logic [2:0] REG_OUT_DB     = 3'd7;

  // Mode codes
  localparam logic [2:0] MODE_ZERO    = 3'd0;
  localparam logic [2:0] MODE_RAW     = 3'd1;
  localparam logic [2:0] MODE_SHAPE_A = 3'd2;
  localparam logic [2:0] MODE_SHAPE_B = 3'd3;

  // Reset values
  localparam logic [2:0]  RST_MODE      = MODE_ZERO;
  localparam logic [15:0] RST_IN_DB     = 16'd3277;
  localparam logic [15:0] RST_CUT_LOW   = 16'd22938;
  localparam logic [15:0] RST_CUT_HIGH  = 16'd22938;
  localparam logic [15:0] RST_GAIN_LOW  = 16'd3277;
  localparam logic [15:0] RST_GAIN_MID  = 16'd3277;
  localparam logic [22:0] RST_LIMIT     = 23'd8388607;
  localparam logic [22:0] RST_OUT_DB    = 23'd0;

  localparam logic [16:0] UNIT15 = 17'd32768;
  localparam logic [31:0] UNIT29 = 32'h2000_0000;

  localparam int NUM_W = 47;   // dividend width
  localparam int QUO_W = 32;   // quotient width
  localparam int DEN_W = 16;   // divisor width

  // Side data carried alongside the divider
  typedef struct packed {
    logic        neg;
    logic [16:0] mag;
    logic [31:0] y2;
    logic        dneg;
  } side_t;

endpackage

FILE: src/jrs_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on jrs_pkg for widths and the side data type.
module jrs_div_pipe (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [jrs_pkg::NUM_W-1:0]   in_num,
  input  logic [jrs_pkg::DEN_W-1:0]   in_den,
  input  jrs_pkg::side_t              in_side,
  output logic                        out_vld,
  output logic [jrs_pkg::QUO_W-1:0]   out_quo,
  output jrs_pkg::side_t              out_side
);
  import jrs_pkg::*;

  logic              vld  [0:QUO_W];
  logic [DEN_W-1:0]  rem  [0:QUO_W];
  logic [QUO_W-1:0]  wrk  [0:QUO_W];
  logic [DEN_W-1:0]  den  [0:QUO_W];
  side_t             side [0:QUO_W];

  // Top dividend bits form the first partial remainder; it stays below den.
  assign vld[0]  = in_vld;
  assign rem[0]  = DEN_W'(in_num[NUM_W-1:QUO_W]);
  assign wrk[0]  = in_num[QUO_W-1:0];
  assign den[0]  = in_den;
  assign side[0] = in_side;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           ge;

    assign trial = {rem[k], wrk[k][QUO_W-1]};
    assign ge    = trial >= {1'b0, den[k]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1]  <= ge ? DEN_W'(trial - {1'b0, den[k]}) : DEN_W'(trial);
        wrk[k+1]  <= {wrk[k][QUO_W-2:0], ge};
        den[k+1]  <= den[k];
        side[k+1] <= side[k];
      end
    end
  end

  assign out_vld  = vld[QUO_W];
  assign out_quo  = wrk[QUO_W];
  assign out_side = side[QUO_W];

endmodule

FILE: src/joystick_rate_shaper.sv
// Top level of the joystick rate shaper: config registers, response curve
// pipeline and output stage. Depends on jrs_pkg and jrs_div_pipe.
//
//   channel   beat fields    handshake
//   stick     stick          stick_valid / stick_stall
//   demand    rate_demand    demand_valid / demand_stall
//   config    cfg_data       cfg_we, cfg_index
//
// One beat per cycle while the output is not stalled; the path runs through the
// 32-stage quotient pipeline of the final curve segment plus nine arithmetic stages.
// Reset clears all valid bits and loads the register defaults.
// A stall at the output freezes every stage at once; nothing is dropped.
module joystick_rate_shaper #(
  parameter int ACQ_GAIN = 5000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        stick_valid,
  output logic        stick_stall,
  input  logic signed [15:0] stick,
  output logic        demand_valid,
  input  logic        demand_stall,
  output logic signed [23:0] rate_demand,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [22:0] cfg_data
);
  import jrs_pkg::*;

  localparam int GW = $clog2(ACQ_GAIN + 1);
  localparam int PW = 32 + GW;
  localparam int MW = (PW - 20 > 24) ? PW - 20 : 24;

  logic [2:0]  mode;
  logic [15:0] input_deadband, cut_low, cut_high, gain_low, gain_mid;
  logic [22:0] demand_limit, output_deadband;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= RST_MODE;
      input_deadband  <= RST_IN_DB;
      cut_low         <= RST_CUT_LOW;
      cut_high        <= RST_CUT_HIGH;
      gain_low        <= RST_GAIN_LOW;
      gain_mid        <= RST_GAIN_MID;
      demand_limit    <= RST_LIMIT;
      output_deadband <= RST_OUT_DB;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:     mode            <= cfg_data[2:0];
        REG_IN_DB:    input_deadband  <= cfg_data[15:0];
        REG_CUT_LOW:  cut_low         <= cfg_data[15:0];
        REG_CUT_HIGH: cut_high        <= cfg_data[15:0];
        REG_GAIN_LOW: gain_low        <= cfg_data[15:0];
        REG_GAIN_MID: gain_mid        <= cfg_data[15:0];
        REG_LIMIT:    demand_limit    <= cfg_data;
        REG_OUT_DB:   output_deadband <= cfg_data;
        default:      mode            <= mode;
      endcase
    end
  end

  // Ordered cutpoints: db <= c1 <= c2 <= 1.0
  logic [16:0] c2, c1, db;
  assign c2 = ({1'b0, cut_high} > UNIT15) ? UNIT15 : {1'b0, cut_high};
  assign c1 = ({1'b0, cut_low} > c2) ? c2 : {1'b0, cut_low};
  assign db = ({1'b0, input_deadband} > c1) ? c1 : {1'b0, input_deadband};

  logic adv, out_vld;
  assign adv          = !(out_vld && demand_stall);
  assign stick_stall  = out_vld && demand_stall;
  assign demand_valid = out_vld;

  // Stage 0: capture
  logic        s0_vld;
  logic [15:0] s0_stick;
  always_ff @(posedge clk) begin
    if (rst) s0_vld <= 1'b0;
    else if (adv) s0_vld <= stick_valid;
  end
  always_ff @(posedge clk) begin
    if (adv) s0_stick <= stick;
  end

  // Stage 1: magnitude, region, segment products
  logic [16:0] sx, a_c, opl, opm;
  logic        zero_c, low_c, fin_c;
  assign sx     = {s0_stick[15], s0_stick};
  assign a_c    = s0_stick[15] ? (~sx + 17'd1) : sx;
  assign zero_c = a_c < db;
  assign low_c  = a_c < c1;
  assign fin_c  = (a_c >= c2) && (c2 != UNIT15);
  assign opl    = low_c ? (a_c - db) : (c1 - db);
  assign opm    = low_c ? 17'd0 : (a_c - c1);

  logic        s1_vld, s1_neg, s1_zero, s1_fin;
  logic [16:0] s1_a;
  logic [31:0] s1_pl, s1_pm;
  logic [15:0] s1_t, s1_den;
  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else if (adv) s1_vld <= s0_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg  <= s0_stick[15];
      s1_a    <= a_c;
      s1_zero <= zero_c;
      s1_fin  <= fin_c;
      s1_pl   <= 32'(opl) * 32'(gain_low);
      s1_pm   <= 32'(opm) * 32'(gain_mid);
      s1_t    <= 16'(a_c - c2);
      s1_den  <= 16'(UNIT15 - c2);
    end
  end

  // Stage 2: mid-segment line value
  logic        s2_vld, s2_neg, s2_fin;
  logic [16:0] s2_a;
  logic [31:0] s2_y2;
  logic [15:0] s2_t, s2_den;
  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else if (adv) s2_vld <= s1_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_neg <= s1_neg;
      s2_a   <= s1_a;
      s2_fin <= s1_fin && !s1_zero;
      s2_y2  <= s1_zero ? 32'd0 : (s1_pl + s1_pm);
      s2_t   <= s1_t;
      s2_den <= s1_den;
    end
  end

  // Stage 3: distance from the line to 1.0, signed as magnitude
  logic        s3_vld, s3_neg, s3_fin, s3_dneg;
  logic [16:0] s3_a;
  logic [31:0] s3_y2, s3_dmag;
  logic [15:0] s3_t, s3_den;
  always_ff @(posedge clk) begin
    if (rst) s3_vld <= 1'b0;
    else if (adv) s3_vld <= s2_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_neg  <= s2_neg;
      s3_a    <= s2_a;
      s3_fin  <= s2_fin;
      s3_y2   <= s2_y2;
      s3_dneg <= s2_y2 > UNIT29;
      s3_dmag <= (s2_y2 > UNIT29) ? (s2_y2 - UNIT29) : (UNIT29 - s2_y2);
      s3_t    <= s2_t;
      s3_den  <= s2_den;
    end
  end

  // Stage 4: dividend for the final segment
  logic             s4_vld;
  logic [NUM_W-1:0] s4_num;
  logic [DEN_W-1:0] s4_den;
  side_t            s4_side;
  always_ff @(posedge clk) begin
    if (rst) s4_vld <= 1'b0;
    else if (adv) s4_vld <= s3_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_num       <= s3_fin ? NUM_W'(48'(s3_t) * 48'(s3_dmag)) : '0;
      s4_den       <= s3_fin ? s3_den : 16'd1;
      s4_side.neg  <= s3_neg;
      s4_side.mag  <= s3_a;
      s4_side.y2   <= s3_y2;
      s4_side.dneg <= s3_dneg;
    end
  end

  logic             dv_vld;
  logic [QUO_W-1:0] dv_quo;
  side_t            dv_side;

  jrs_div_pipe u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (s4_vld),
    .in_num   (s4_num),
    .in_den   (s4_den),
    .in_side  (s4_side),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_side)
  );

  // Shaped value
  logic        sy_vld, sy_neg;
  logic [16:0] sy_a;
  logic [31:0] sy_y;
  always_ff @(posedge clk) begin
    if (rst) sy_vld <= 1'b0;
    else if (adv) sy_vld <= dv_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sy_neg <= dv_side.neg;
      sy_a   <= dv_side.mag;
      sy_y   <= dv_side.dneg ? (dv_side.y2 - dv_quo) : (dv_side.y2 + dv_quo);
    end
  end

  // Gain
  logic          sp_vld, sp_neg;
  logic [16:0]   sp_a;
  logic [PW-1:0] sp_prod;
  always_ff @(posedge clk) begin
    if (rst) sp_vld <= 1'b0;
    else if (adv) sp_vld <= sy_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sp_neg  <= sy_neg;
      sp_a    <= sy_a;
      sp_prod <= PW'(sy_y) * PW'(ACQ_GAIN);
    end
  end

  // Round, select by mode, limit
  logic [PW:0]   rsum;
  logic [MW-1:0] shaped, raw, mag_c;
  assign rsum   = {1'b0, sp_prod} + (PW+1)'(1 << 20);
  assign shaped = MW'(rsum >> 21);
  assign raw    = MW'((sp_a + 17'd64) >> 7);

  always_comb begin
    unique case (mode)
      MODE_RAW:                  mag_c = raw;
      MODE_SHAPE_A, MODE_SHAPE_B: mag_c = shaped;
      default:                   mag_c = '0;
    endcase
  end

  logic        sl_vld, sl_neg;
  logic [22:0] sl_mag;
  always_ff @(posedge clk) begin
    if (rst) sl_vld <= 1'b0;
    else if (adv) sl_vld <= sp_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) begin
      sl_neg <= sp_neg;
      sl_mag <= (mag_c > MW'(demand_limit)) ? demand_limit : 23'(mag_c);
    end
  end

  // Output deadband and sign
  logic [22:0] dbm;
  assign dbm = (sl_mag < output_deadband) ? 23'd0 : sl_mag;

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (adv) out_vld <= sl_vld;
  end
  always_ff @(posedge clk) begin
    if (adv) rate_demand <= sl_neg ? (24'd0 - {1'b0, dbm}) : {1'b0, dbm};
  end

endmodule
